[rtl/cdoc_pkg.sv]
// Shared types, constants and month-length lookup for the calendar date converter.
// Used by cdoc_leap, cdoc_cell and calendar_date_ordinal_converter_top.
`default_nettype none

package cdoc_pkg;

    localparam int YEAR_BITS_DEFAULT = 16;
    localparam int NUM_MONTHS        = 12;
    localparam int SUM_BITS          = 12;
    localparam int RECIP_25          = 1311;
    localparam int RECIP_SHIFT       = 15;

    localparam logic MODE_TO_ORDINAL = 1'b0;
    localparam logic MODE_TO_DATE    = 1'b1;

    localparam logic [3:0] FIRST_MONTH   = 4'd1;
    localparam logic [3:0] LAST_MONTH    = 4'd12;
    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    typedef struct packed {
        logic       mode;
        logic       leap;
        logic       err;
        logic [3:0] month;
        logic [4:0] day;
        logic [8:0] acc;
        logic [8:0] rem;
        logic       done;
        logic [3:0] om;
        logic [4:0] od;
    } cdoc_pkt_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // 16^j mod 25, period five
    function automatic logic [4:0] mod25_weight(input int idx);
        logic [4:0] w;
        case (idx % 5)
            0:       w = 5'd1;
            1:       w = 5'd16;
            2:       w = 5'd6;
            3:       w = 5'd21;
            default: w = 5'd11;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/calendar_date_ordinal_converter_top.sv]
// Gregorian date <-> day-of-year converter: leap front end, twelve month cells, output register.
// Depends on cdoc_pkg, cdoc_leap and cdoc_cell.
//
// Takes one transaction per cycle: two front-end stages find the leap flag and check ranges,
// then the transaction walks a chain of twelve month cells, one cell per cycle, into the
// output register. The whole chain holds while a result waits in the output register and
// m_ready is low.
`default_nettype none

module calendar_date_ordinal_converter_top #(
    parameter int YEAR_BITS = cdoc_pkg::YEAR_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_mode,
    input  wire logic [YEAR_BITS-1:0]  s_year,
    input  wire logic [3:0]            s_month,
    input  wire logic [4:0]            s_day,
    input  wire logic [8:0]            s_ordinal,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [8:0]                 m_day_number,
    output logic [3:0]                 m_out_month,
    output logic [4:0]                 m_out_day,
    output logic                       m_is_leap,
    output logic                       m_error
);

    localparam int N = cdoc_pkg::NUM_MONTHS;

    logic                 en;
    logic                 chain_valid [N+1];
    cdoc_pkg::cdoc_pkt_t  chain_pkt   [N+1];
    cdoc_pkg::cdoc_pkt_t  last;

    logic       m_valid_reg;
    logic [8:0] day_number_reg;
    logic [3:0] out_month_reg;
    logic [4:0] out_day_reg;
    logic       is_leap_reg;
    logic       error_reg;

    logic [8:0] day_number_next;
    logic [3:0] out_month_next;
    logic [4:0] out_day_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    cdoc_leap #(
        .YEAR_BITS (YEAR_BITS)
    ) u_leap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .mode      (s_mode),
        .year      (s_year),
        .month     (s_month),
        .day       (s_day),
        .ordinal   (s_ordinal),
        .out_valid (chain_valid[0]),
        .out_pkt   (chain_pkt[0])
    );

    for (genvar k = 1; k <= N; k++) begin : g_cell
        cdoc_cell #(
            .MONTH (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[k-1]),
            .in_pkt    (chain_pkt[k-1]),
            .out_valid (chain_valid[k]),
            .out_pkt   (chain_pkt[k])
        );
    end

    assign last = chain_pkt[N];

    always_comb begin
        day_number_next = '0;
        out_month_next  = '0;
        out_day_next    = '0;
        if (!last.err) begin
            if (last.mode == cdoc_pkg::MODE_TO_ORDINAL) begin
                day_number_next = last.acc;
            end else begin
                out_month_next = last.om;
                out_day_next   = last.od;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= chain_valid[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            day_number_reg <= day_number_next;
            out_month_reg  <= out_month_next;
            out_day_reg    <= out_day_next;
            is_leap_reg    <= last.leap;
            error_reg      <= last.err;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_day_number = day_number_reg;
    assign m_out_month  = out_month_reg;
    assign m_out_day    = out_day_reg;
    assign m_is_leap    = is_leap_reg;
    assign m_error      = error_reg;

endmodule

`default_nettype wire

[rtl/cdoc_leap.sv]
// Input stages: leap-year test through a folded mod-25 residue and first range checks.
// Depends on cdoc_pkg.
`default_nettype none

module cdoc_leap #(
    parameter int YEAR_BITS = cdoc_pkg::YEAR_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic                   mode,
    input  wire logic [YEAR_BITS-1:0]   year,
    input  wire logic [3:0]             month,
    input  wire logic [4:0]             day,
    input  wire logic [8:0]             ordinal,
    output logic                        out_valid,
    output cdoc_pkg::cdoc_pkt_t         out_pkt
);

    localparam int NIB      = (YEAR_BITS + 3) / 4;
    localparam int SB       = cdoc_pkg::SUM_BITS;
    localparam int PROD_BITS = SB + 11;

    logic [NIB*4-1:0] year_pad;
    logic [8:0]       term [NIB];
    logic [SB-1:0]    sum_next;

    logic             s1_valid_reg;
    logic [SB-1:0]    sum_reg;
    logic             zero_reg;
    logic             low2_reg;
    logic             low4_reg;
    logic             mode_reg;
    logic [3:0]       month_reg;
    logic [4:0]       day_reg;
    logic [8:0]       ordinal_reg;

    logic                 s2_valid_reg;
    cdoc_pkg::cdoc_pkt_t  pkt_reg;
    cdoc_pkg::cdoc_pkt_t  pkt_next;

    logic [PROD_BITS-1:0] prod;
    logic [7:0]           quot;
    logic [SB-1:0]        resid;
    logic                 leap;
    logic [8:0]           year_len;

    assign year_pad = (NIB*4)'(year);

    for (genvar j = 0; j < NIB; j++) begin : g_term
        assign term[j] = 9'(year_pad[4*j +: 4]) * 9'(cdoc_pkg::mod25_weight(j));
    end

    always_comb begin
        sum_next = '0;
        for (int j = 0; j < NIB; j++) begin
            sum_next = sum_next + SB'(term[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg     <= sum_next;
            zero_reg    <= (year == '0);
            low2_reg    <= (year[1:0] == 2'd0);
            low4_reg    <= (year[3:0] == 4'd0);
            mode_reg    <= mode;
            month_reg   <= month;
            day_reg     <= day;
            ordinal_reg <= ordinal;
        end
    end

    assign prod     = PROD_BITS'(sum_reg) * PROD_BITS'(cdoc_pkg::RECIP_25);
    assign quot     = prod[cdoc_pkg::RECIP_SHIFT +: 8];
    assign resid    = sum_reg - SB'(quot) * SB'(8'd25);
    assign leap     = low2_reg && ((resid != '0) || low4_reg);
    assign year_len = cdoc_pkg::DAYS_PER_YEAR + 9'(leap);

    always_comb begin
        pkt_next       = '0;
        pkt_next.mode  = mode_reg;
        pkt_next.leap  = leap;
        pkt_next.month = month_reg;
        pkt_next.day   = day_reg;
        pkt_next.rem   = ordinal_reg;
        if (mode_reg == cdoc_pkg::MODE_TO_ORDINAL) begin
            pkt_next.err = zero_reg || (month_reg < cdoc_pkg::FIRST_MONTH)
                || (month_reg > cdoc_pkg::LAST_MONTH) || (day_reg == 5'd0);
        end else begin
            pkt_next.err = zero_reg || (ordinal_reg == 9'd0) || (ordinal_reg > year_len);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

`default_nettype wire

[rtl/cdoc_cell.sv]
// One month cell of the converter chain: applies its month to the passing transaction.
// Depends on cdoc_pkg.
`default_nettype none

module cdoc_cell #(
    parameter int MONTH = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire cdoc_pkg::cdoc_pkt_t  in_pkt,
    output logic                      out_valid,
    output cdoc_pkg::cdoc_pkt_t       out_pkt
);

    localparam logic [3:0] MONTH_CODE = 4'(MONTH);

    logic                 valid_reg;
    cdoc_pkg::cdoc_pkt_t  pkt_reg;
    cdoc_pkg::cdoc_pkt_t  pkt_next;
    logic [4:0]           len;

    assign len = cdoc_pkg::month_len(in_pkt.leap, MONTH_CODE);

    always_comb begin
        pkt_next = in_pkt;
        if (in_pkt.mode == cdoc_pkg::MODE_TO_ORDINAL) begin
            if (MONTH_CODE < in_pkt.month) begin
                pkt_next.acc = in_pkt.acc + 9'(len);
            end else if (MONTH_CODE == in_pkt.month) begin
                pkt_next.acc = in_pkt.acc + 9'(in_pkt.day);
                if (in_pkt.day > len) begin
                    pkt_next.err = 1'b1;
                end
            end
        end else if (!in_pkt.done) begin
            if ((MONTH_CODE == cdoc_pkg::LAST_MONTH) || (in_pkt.rem <= 9'(len))) begin
                pkt_next.done = 1'b1;
                pkt_next.om   = MONTH_CODE;
                pkt_next.od   = in_pkt.rem[4:0];
            end else begin
                pkt_next.rem  = in_pkt.rem - 9'(len);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

`default_nettype wire
